// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
// spq_pkg: shared types and codes for the sorted priority queue
// no dependencies; used by spq_cell, sorted_priority_queue, spq_scoreboard and the testbench
package spq_pkg;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

// ----- src/spq_cell.sv -----
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted row, holds a key and a value
// depends on spq_pkg for the control struct
module spq_cell #(
	parameter int VALUE_WIDTH = 16,
	parameter int KEY_WIDTH   = 8
) (
	input  logic                    clk,
	input  spq_pkg::cell_ctrl_t     ctrl,
	input  logic                    occ,
	input  logic [KEY_WIDTH-1:0]    new_key,
	input  logic [VALUE_WIDTH-1:0]  new_value,
	input  logic                    left_gt,
	input  logic [KEY_WIDTH-1:0]    left_key,
	input  logic [VALUE_WIDTH-1:0]  left_value,
	input  logic [KEY_WIDTH-1:0]    right_key,
	input  logic [VALUE_WIDTH-1:0]  right_value,
	output logic [KEY_WIDTH-1:0]    key,
	output logic [VALUE_WIDTH-1:0]  value,
	output logic                    gt
);

	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;

	assign gt    = occ && (key_q > new_key);
	assign key   = key_q;
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			key_q   <= right_key;
			value_q <= right_value;
		end else if (ctrl.push && !gt) begin
			if (left_gt) begin
				key_q   <= new_key;
				value_q <= new_value;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
			end
		end
	end

endmodule

// ----- src/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// sorted_priority_queue: bounded priority queue as a row of sorted cells
// depends on spq_pkg and spq_cell
//
//  channel | dir | tdata                 | tuser
//  s_*     | in  | item_value, item_key  | opcode
//  m_*     | out | out_value             | out_valid, is_empty, push_dropped
//
// one beat per cycle while s_tready is high: every cell compares against the pushed key at once,
// so the row updates at the accepting edge and the result beat is presented in the next cycle
// the result sits in one output register; s_tready drops only while it is held unaccepted
// arst_n clears the fill count and the output valid; cell contents need no reset
module sorted_priority_queue #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 16,
	parameter int KEY_WIDTH   = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              s_tvalid,
	output logic                                              s_tready,
	input  logic [((VALUE_WIDTH + KEY_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // item_value, item_key
	input  logic [0:0]                                        s_tuser,  // opcode
	output logic                                              m_tvalid,
	input  logic                                              m_tready,
	output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0]            m_tdata,  // out_value
	output logic [2:0]                                        m_tuser
	// m_tuser: out_valid, is_empty, push_dropped
);

	localparam int IN_DATA_W  = ((VALUE_WIDTH + KEY_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int CW         = $clog2(DEPTH + 1);

	logic [CW-1:0]          count_q;
	logic [VALUE_WIDTH-1:0] in_value;
	logic [KEY_WIDTH-1:0]   in_key;
	logic                   accept;
	logic                   is_pop;
	logic                   full;
	logic                   empty;
	spq_pkg::cell_ctrl_t    ctrl;
	logic [CW-1:0]          count_nxt;

	logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
	logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
	logic                   cell_gt    [DEPTH];

	logic [VALUE_WIDTH-1:0] res_value_q;
	logic                   res_valid_q;
	logic                   res_empty_q;
	logic                   res_drop_q;
	logic                   m_valid_q;

	assign in_value = s_tdata[VALUE_WIDTH-1:0];
	assign in_key   = s_tdata[VALUE_WIDTH+KEY_WIDTH-1:VALUE_WIDTH];
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_pop   = (s_tuser[0] == spq_pkg::OP_POP);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	assign ctrl.push = accept && !is_pop && !full;
	assign ctrl.pop  = accept && is_pop && !empty;

	always_comb begin
		count_nxt = count_q;
		if (ctrl.push) begin
			count_nxt = count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_nxt = count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   occ;
		logic                   l_gt;
		logic [KEY_WIDTH-1:0]   l_key;
		logic [VALUE_WIDTH-1:0] l_value;
		logic [KEY_WIDTH-1:0]   r_key;
		logic [VALUE_WIDTH-1:0] r_value;

		assign occ = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign l_gt    = 1'b1;
			assign l_key   = in_key;
			assign l_value = in_value;
		end else begin : g_body
			assign l_gt    = cell_gt[i-1];
			assign l_key   = cell_key[i-1];
			assign l_value = cell_value[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_key   = '0;
			assign r_value = '0;
		end else begin : g_mid
			assign r_key   = cell_key[i+1];
			assign r_value = cell_value[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.KEY_WIDTH  (KEY_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occ        (occ),
			.new_key    (in_key),
			.new_value  (in_value),
			.left_gt    (l_gt),
			.left_key   (l_key),
			.left_value (l_value),
			.right_key  (r_key),
			.right_value(r_value),
			.key        (cell_key[i]),
			.value      (cell_value[i]),
			.gt         (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_value_q <= ctrl.pop ? cell_value[0] : '0;
			res_valid_q <= ctrl.pop;
			res_empty_q <= (count_nxt == '0);
			res_drop_q  <= !is_pop && full;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(res_value_q);
	assign m_tuser  = {res_drop_q, res_empty_q, res_valid_q};

endmodule

// ----- src/spq_checker.sv -----
`timescale 1ns / 1ps
// spq_checker: port-level checks for sorted_priority_queue
// bound to the top level below; no package dependency
module spq_checker #(
	parameter int VALUE_WIDTH = 16,
	parameter int OUT_DATA_W  = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [2:0]            m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_pop_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
		else $error("popped entry and dropped push in one beat");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[VALUE_WIDTH-1:0] == '0))
		else $error("nonzero value without a popped entry");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tuser[1])
		else $error("dropped push reported an empty queue");

endmodule

bind sorted_priority_queue spq_checker #(
	.VALUE_WIDTH(VALUE_WIDTH),
	.OUT_DATA_W (OUT_DATA_W)
) u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ----- verif/spq_checker.sv -----
`timescale 1ns / 1ps
// spq_scoreboard: watches both streams of the sorted priority queue and checks result beats
// keeps its own sorted copy of the queue to predict results; depends on spq_pkg
module spq_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // item_value, item_key
	input  logic [0:0]  s_tuser,  // opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // out_value
	input  logic [2:0]  m_tuser,  // out_valid, is_empty, push_dropped
	output int          fail_count,
	output int          results_owed,
	output int          n_push,
	output int          n_pop,
	output int          n_drop,
	output int          n_empty_pop,
	output int          peak_fill
);

	localparam int SLOTS      = 16;
	localparam int MAX_REPORT = 10;

	typedef struct packed {
		logic [15:0] value;
		logic        valid;
		logic        empty;
		logic        dropped;
	} pq_result_t;

	logic [7:0]  row_key   [SLOTS];
	logic [15:0] row_value [SLOTS];
	int          fill;
	int          mismatches;
	int          pushes, pops, drops, empty_pops, fill_max;
	pq_result_t  awaited_results [$];

	function automatic pq_result_t apply_queue_op(spq_pkg::opcode_t op,
			logic [15:0] v, logic [7:0] k);
		pq_result_t r;
		int         pos;
		r = '0;
		if (op == spq_pkg::OP_PUSH) begin
			if (fill >= SLOTS) begin
				r.dropped = 1'b1;
			end else begin
				pos = 0;
				while (pos < fill && row_key[pos] > k)
					pos++;
				for (int i = fill; i > pos; i--) begin
					row_key[i]   = row_key[i - 1];
					row_value[i] = row_value[i - 1];
				end
				row_key[pos]   = k;
				row_value[pos] = v;
				fill++;
			end
		end else if (fill > 0) begin
			r.value = row_value[0];
			r.valid = 1'b1;
			for (int i = 1; i < fill; i++) begin
				row_key[i - 1]   = row_key[i];
				row_value[i - 1] = row_value[i];
			end
			fill--;
		end
		r.empty = (fill == 0);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		pq_result_t want;
		pq_result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = apply_queue_op(spq_pkg::opcode_t'(s_tuser[0]),
					s_tdata[15:0], s_tdata[23:16]);
				awaited_results.push_back(want);
				if (spq_pkg::opcode_t'(s_tuser[0]) == spq_pkg::OP_PUSH) begin
					pushes++;
					if (want.dropped)
						drops++;
				end else begin
					pops++;
					if (!want.valid)
						empty_pops++;
				end
				if (fill > fill_max)
					fill_max = fill;
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tuser[0], m_tuser[1], m_tuser[2]};
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display("%0t unexpected result beat:", $time,
							" value=%h valid=%b empty=%b dropped=%b",
							got.value, got.valid, got.empty, got.dropped);
				end else begin
					want = awaited_results.pop_front();
					if (got.value !== want.value || got.valid !== want.valid ||
							got.empty !== want.empty || got.dropped !== want.dropped) begin
						mismatches++;
						if (mismatches <= MAX_REPORT)
							$display("%0t mismatch:", $time,
								" expected value=%h valid=%b empty=%b dropped=%b,",
								want.value, want.valid, want.empty, want.dropped,
								" got value=%h valid=%b empty=%b dropped=%b",
								got.value, got.valid, got.empty, got.dropped);
					end
				end
			end
		end
		fail_count   <= mismatches;
		results_owed <= awaited_results.size();
		n_push       <= pushes;
		n_pop        <= pops;
		n_drop       <= drops;
		n_empty_pop  <= empty_pops;
		peak_fill    <= fill_max;
	end

endmodule

// ----- verif/tb_sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// tb_sorted_priority_queue: stimulus and verdict for the sorted priority queue
// depends on spq_pkg, sorted_priority_queue and spq_scoreboard
module tb_sorted_priority_queue;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int KEYS_ANY       = 0;
	localparam int KEYS_NARROW    = 1;
	localparam int KEYS_EDGE      = 2;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // item_value, item_key
	logic [0:0]  s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // out_value
	logic [2:0]  m_tuser;  // out_valid, is_empty, push_dropped

	int fail_count, results_owed, n_push, n_pop, n_drop, n_empty_pop, peak_fill;
	int tx_idle_pct, rx_stall_pct, quiet_cycles;
	bit hold_request;

	sorted_priority_queue u_top (.*);

	spq_scoreboard u_check (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic send_beat(input spq_pkg::opcode_t op, input logic [15:0] v,
			input logic [7:0] k);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {k, v};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_burst(input int beats, input int push_pct, input int key_mode);
		spq_pkg::opcode_t op;
		logic [15:0]      v;
		logic [7:0]       k;
		for (int n = 0; n < beats; n++) begin
			op = ($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
			v  = 16'($urandom);
			case (key_mode)
				KEYS_NARROW: k = 8'($urandom_range(0, 3));
				KEYS_EDGE:   k = $urandom_range(0, 1) ? 8'hff : 8'h00;
				default:     k = 8'($urandom);
			endcase
			send_beat(op, v, k);
		end
	endtask

	// fill-heavy, drain-heavy and balanced bursts so the queue swings between full and empty
	task automatic run_phase(input int idle_pct, input int stall_pct);
		tx_idle_pct  = idle_pct;
		rx_stall_pct = stall_pct;
		repeat (3) begin
			random_burst(24, 80, $urandom_range(0, 2));
			random_burst(24, 20, $urandom_range(0, 2));
			random_burst(18, 55, $urandom_range(0, 2));
		end
	endtask

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_sorted_priority_queue: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_request = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty, extremes, equal keys, fill up, push on full, a few pops
		send_beat(spq_pkg::OP_POP, 16'hffff, 8'hff);
		send_beat(spq_pkg::OP_PUSH, 16'h0000, 8'h00);
		send_beat(spq_pkg::OP_PUSH, 16'hffff, 8'hff);
		send_beat(spq_pkg::OP_PUSH, 16'h1234, 8'h80);
		send_beat(spq_pkg::OP_PUSH, 16'h5678, 8'h80);
		send_beat(spq_pkg::OP_PUSH, 16'haaaa, 8'h80);
		send_beat(spq_pkg::OP_PUSH, 16'h5555, 8'h00);
		send_beat(spq_pkg::OP_PUSH, 16'h0001, 8'hff);
		repeat (9) send_beat(spq_pkg::OP_PUSH, 16'($urandom), 8'($urandom));
		send_beat(spq_pkg::OP_PUSH, 16'hbeef, 8'hff);
		repeat (3) send_beat(spq_pkg::OP_POP, 16'($urandom), 8'($urandom));

		run_phase(0, 0);
		run_phase(74, 0);
		run_phase(0, 74);
		run_phase(35, 35);

		// long receiver hold-off while the sender keeps offering beats
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_request = 1'b1;
		random_burst(40, 50, KEYS_ANY);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d pushes (%0d dropped on full)", n_push, n_drop,
			" and %0d pops (%0d on empty), peak fill %0d", n_pop, n_empty_pop, peak_fill);
		$display("idle mixes: none, sender 74%%, receiver 74%%, both 35%%,",
			" plus a %0d-cycle hold-off", HOLD_CYCLES);
		if (fail_count == 0 && results_owed == 0) begin
			$display("tb_sorted_priority_queue: PASS");
		end else begin
			$display("tb_sorted_priority_queue: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
verif/spq_checker.sv
verif/tb_sorted_priority_queue.sv
